### hw/rtl/bmfa_pkg.sv
// Shared constants, types and helpers of the bitmap first-free allocator.
package bmfa_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int WORD_W      = 32;
    localparam int WORDS       = MAX_ENTRIES / WORD_W;
    localparam int WADDR_W     = $clog2(WORDS);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int POS_W       = WADDR_W + BIT_W;

    localparam int ID_W        = 11;
    localparam int COUNT_W     = 11;
    localparam int RESV_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = COUNT_W'(MAX_ENTRIES);
    localparam logic [RESV_W-1:0]  RESERVED_RST    = RESV_W'(8);

    // Limits seen by the sequencer
    typedef struct packed {
        logic [COUNT_W-1:0] entries;
        logic [RESV_W-1:0]  reserved;
    } cfg_t;

    // One finished result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     granted_id;
        logic [COUNT_W-1:0]  free_count;
    } res_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } hit_t;

    // Lowest set bit of a bitmap word
    function automatic hit_t find_first(input logic [WORD_W-1:0] avail);
        hit_t h;
        h.found = 1'b0;
        h.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                h.found = 1'b1;
                h.idx   = BIT_W'(i);
            end
        end
        return h;
    endfunction

endpackage

### hw/rtl/bmfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/bmfa_ctrl.sv
// Command sequencer: word scan, read-modify-write of the bitmap and used count.
module bmfa_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_cmd,
    input  logic [bmfa_pkg::ID_W-1:0]        in_id,
    input  bmfa_pkg::cfg_t                   cfg,
    output logic                             push_valid,
    input  logic                             push_ready,
    output bmfa_pkg::res_t                   res,
    output logic                             ram_we,
    output logic [bmfa_pkg::WADDR_W-1:0]     ram_waddr,
    output logic [bmfa_pkg::WORD_W-1:0]      ram_wdata,
    output logic [bmfa_pkg::WADDR_W-1:0]     ram_raddr,
    input  logic [bmfa_pkg::WORD_W-1:0]      ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CHK  = 3'b010,
        S_PUSH = 3'b100
    } state_t;

    state_t                             state_reg, state_next;
    logic                               cmd_reg, cmd_next;
    logic [bmfa_pkg::ID_W-1:0]          id_reg, id_next;
    logic [bmfa_pkg::WADDR_W-1:0]       addr_reg, addr_next;
    logic [bmfa_pkg::COUNT_W-1:0]       used_reg, used_next;
    logic [bmfa_pkg::WORDS-1:0]         rowvalid_reg, rowvalid_next;
    logic [bmfa_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [bmfa_pkg::ID_W-1:0]          granted_reg, granted_next;

    logic [bmfa_pkg::COUNT_W-1:0]       free_cnt;
    logic [bmfa_pkg::POS_W-1:0]         n_m1;
    logic [bmfa_pkg::POS_W-1:0]         id_m1;
    logic [bmfa_pkg::POS_W-1:0]         hold_m1;
    logic [bmfa_pkg::WORD_W-1:0]        word;
    logic [bmfa_pkg::WORD_W-1:0]        low_ok;
    logic [bmfa_pkg::WORD_W-1:0]        high_ok;
    logic [bmfa_pkg::WORD_W-1:0]        avail;
    logic [bmfa_pkg::WADDR_W-1:0]       first_word;
    logic [bmfa_pkg::WADDR_W-1:0]       last_word;
    logic [bmfa_pkg::BIT_W-1:0]         free_bit;
    bmfa_pkg::hit_t                     hit;

    assign free_cnt = (cfg.entries > used_reg) ? (cfg.entries - used_reg) : '0;
    assign n_m1     = bmfa_pkg::POS_W'(cfg.entries - 11'd1);
    assign id_m1    = bmfa_pkg::POS_W'(in_id - 11'd1);
    assign hold_m1  = bmfa_pkg::POS_W'(id_reg - 11'd1);
    assign free_bit = hold_m1[bmfa_pkg::BIT_W-1:0];

    assign first_word = cfg.reserved[bmfa_pkg::POS_W-1:bmfa_pkg::BIT_W];
    assign last_word  = n_m1[bmfa_pkg::POS_W-1:bmfa_pkg::BIT_W];

    // Rows never written read as all free
    assign word = rowvalid_reg[addr_reg] ? ram_rdata : '0;

    assign low_ok  = (addr_reg == first_word)
                   ? ({bmfa_pkg::WORD_W{1'b1}} << cfg.reserved[bmfa_pkg::BIT_W-1:0])
                   : {bmfa_pkg::WORD_W{1'b1}};
    assign high_ok = (addr_reg == last_word)
                   ? ({bmfa_pkg::WORD_W{1'b1}} >>
                      (bmfa_pkg::BIT_W'(bmfa_pkg::WORD_W - 1) - n_m1[bmfa_pkg::BIT_W-1:0]))
                   : {bmfa_pkg::WORD_W{1'b1}};
    assign avail   = ~word & low_ok & high_ok;
    assign hit     = bmfa_pkg::find_first(avail);

    assign in_ready   = (state_reg == S_IDLE);
    assign push_valid = (state_reg == S_PUSH);
    assign ram_waddr  = addr_reg;

    assign res.status     = status_reg;
    assign res.granted_id = granted_reg;
    assign res.free_count = free_cnt;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        addr_next     = addr_reg;
        used_next     = used_reg;
        rowvalid_next = rowvalid_reg;
        status_next   = status_reg;
        granted_next  = granted_reg;
        ram_raddr     = addr_reg;
        ram_we        = 1'b0;
        ram_wdata     = word;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_cmd;
                    id_next  = in_id;
                    if (in_cmd == bmfa_pkg::CMD_ALLOC)
                    begin
                        if (free_cnt == '0 ||
                            {1'b0, cfg.reserved} >= cfg.entries)
                        begin
                            status_next  = bmfa_pkg::ST_FULL;
                            granted_next = '0;
                            state_next   = S_PUSH;
                        end
                        else
                        begin
                            ram_raddr  = first_word;
                            addr_next  = first_word;
                            state_next = S_CHK;
                        end
                    end
                    else
                    begin
                        if (in_id == '0 || in_id > cfg.entries)
                        begin
                            status_next  = bmfa_pkg::ST_BAD;
                            granted_next = '0;
                            state_next   = S_PUSH;
                        end
                        else
                        begin
                            ram_raddr  = id_m1[bmfa_pkg::POS_W-1:bmfa_pkg::BIT_W];
                            addr_next  = id_m1[bmfa_pkg::POS_W-1:bmfa_pkg::BIT_W];
                            state_next = S_CHK;
                        end
                    end
                end
            end

            S_CHK:
            begin
                if (cmd_reg == bmfa_pkg::CMD_FREE)
                begin
                    if (word[free_bit])
                    begin
                        ram_we       = 1'b1;
                        ram_wdata    = word & ~(bmfa_pkg::WORD_W'(1) << free_bit);
                        used_next    = (used_reg != '0) ? used_reg - 11'd1 : used_reg;
                        status_next  = bmfa_pkg::ST_OK;
                        granted_next = id_reg;
                    end
                    else
                    begin
                        status_next  = bmfa_pkg::ST_BAD;
                        granted_next = '0;
                    end
                    state_next = S_PUSH;
                end
                else if (hit.found)
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = word | (bmfa_pkg::WORD_W'(1) << hit.idx);
                    used_next    = used_reg + 11'd1;
                    status_next  = bmfa_pkg::ST_OK;
                    granted_next = bmfa_pkg::ID_W'({addr_reg, hit.idx}) + 11'd1;
                    state_next   = S_PUSH;
                end
                else if (addr_reg == last_word)
                begin
                    status_next  = bmfa_pkg::ST_FULL;
                    granted_next = '0;
                    state_next   = S_PUSH;
                end
                else
                begin
                    // advance to the next word; its data lands next cycle
                    addr_next = addr_reg + 1'b1;
                    ram_raddr = addr_reg + 1'b1;
                end
                if (ram_we)
                begin
                    rowvalid_next[addr_reg] = 1'b1;
                end
            end

            S_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            rowvalid_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            rowvalid_reg <= rowvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        addr_reg    <= addr_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

`ifndef ASSERT_OFF
    a_we_in_chk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CHK))
        else $error("bitmap write outside the check state");

    a_we_then_push: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (state_reg == S_PUSH && status_reg == bmfa_pkg::ST_OK))
        else $error("bitmap write not followed by a good result");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= bmfa_pkg::COUNT_W'(bmfa_pkg::MAX_ENTRIES))
        else $error("used count beyond capacity");

    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && cmd_reg == bmfa_pkg::CMD_ALLOC && status_reg == bmfa_pkg::ST_OK)
        |-> (granted_reg > {1'b0, cfg.reserved} && granted_reg <= cfg.entries))
        else $error("allocated id outside the search range");
`endif

endmodule

### hw/rtl/bitmap_first_free_allocator.sv
// Top level of the bitmap first-free allocator: config registers, bitmap RAM, output register.
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tuser: command; tdata: entry_id
//  m_*      | out | m_tvalid/m_tready  | tuser: status; tdata: granted_id, free_count
//  cfg_*    | in  | cfg_we             | cfg_index, cfg_data
//
// A free reads its bitmap word and clears the bit in the check state, then passes the
// result to the output register; an allocate scans the 32-bit bitmap words in order until one has a free bit.
// A command refused without a RAM access (bad id, nothing free) goes straight to the result.
// The scan rate is set by the single read port of the bitmap RAM.
// Commands are handled one at a time; the next is taken once the result sits in
// the output register, while that word still waits for m_tready.
// Reset needs no clearing pass: a valid bit per RAM row makes unwritten rows read free.
module bitmap_first_free_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [10:0] entry_id
    input  logic                                s_tuser,   // [0] command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // [10:0] granted_id, [21:11] free_count
    output logic [bmfa_pkg::STATUS_W-1:0]       m_tuser,   // [1:0] status
    input  logic                                cfg_we,
    input  logic [bmfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [bmfa_pkg::COUNT_W-1:0]   entry_count_reg;
    logic [bmfa_pkg::RESV_W-1:0]    reserved_reg;
    logic                           m_tvalid_reg, m_tvalid_next;
    bmfa_pkg::res_t                 out_reg;

    bmfa_pkg::cfg_t                 cfg;
    bmfa_pkg::res_t                 res;
    logic                           push_valid;
    logic                           push_ready;
    logic                           ram_we;
    logic [bmfa_pkg::WADDR_W-1:0]   ram_waddr;
    logic [bmfa_pkg::WORD_W-1:0]    ram_wdata;
    logic [bmfa_pkg::WADDR_W-1:0]   ram_raddr;
    logic [bmfa_pkg::WORD_W-1:0]    ram_rdata;

    // Saturate the entry count at the bitmap size
    assign cfg.entries  = (entry_count_reg > bmfa_pkg::COUNT_W'(bmfa_pkg::MAX_ENTRIES))
                        ? bmfa_pkg::COUNT_W'(bmfa_pkg::MAX_ENTRIES) : entry_count_reg;
    assign cfg.reserved = reserved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= bmfa_pkg::ENTRY_COUNT_RST;
            reserved_reg    <= bmfa_pkg::RESERVED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmfa_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_data;
                bmfa_pkg::CFG_RESERVED:    reserved_reg    <= cfg_data[bmfa_pkg::RESV_W-1:0];
                default:                   reserved_reg    <= reserved_reg;
            endcase
        end
    end

    bmfa_ram #(
        .WIDTH (bmfa_pkg::WORD_W),
        .DEPTH (bmfa_pkg::WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_id      (s_tdata[bmfa_pkg::ID_W-1:0]),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Output register: load when empty or being drained
    assign push_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (push_ready)
        begin
            m_tvalid_next = push_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {2'b00, out_reg.free_count, out_reg.granted_id};

endmodule
